### hw/rtl/itaf_pkg.sv
// Shared types, codes and constants for the integer to ASCII formatter.
`timescale 1ns / 1ps

package itaf_pkg;

   // Widest field width honored; wider requests saturate to it.
   localparam int MAX_WIDTH = 63;

   // Default queue depths for the top level parameters.
   localparam int DEF_ITEM_DEPTH = 2;
   localparam int DEF_RSP_DEPTH  = 2;

   // Digit register: 22 four-bit digit slots cover 20 decimal, 16 hex or 22 octal digits.
   localparam int NUM_DIGITS = 22;
   localparam int DIGIT_BITS = NUM_DIGITS * 4;

   // Conversion modes.
   localparam logic [1:0] MODE_UDEC = 2'd0;
   localparam logic [1:0] MODE_SDEC = 2'd1;
   localparam logic [1:0] MODE_HEX  = 2'd2;
   localparam logic [1:0] MODE_OCT  = 2'd3;

   // Characters that are not digits.
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [127:0] DIGIT_CHARS = "0123456789ABCDEF";

   // One classified number on its way from the front end to the back end.
   typedef struct packed {
      logic [63:0] mag;
      logic [1:0]  mode;
      logic        neg;
      logic [5:0]  width;
      logic        left;
      logic [7:0]  fill;
   } item_type;

   // One output word.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } rsp_type;

   // ASCII character of one digit value.
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [6:0] top;
      top = 7'd127 - {d, 3'b000};
      return DIGIT_CHARS[top -: 8];
   endfunction

endpackage

### hw/rtl/itaf_queue.sv
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps

module itaf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer and fill count update with wraparound at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### hw/rtl/itaf_front.sv
// Front end: accepts numbers, takes the magnitude and classifies the format.
`timescale 1ns / 1ps

module itaf_front
   import itaf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_width,
   input  logic        req_left_justify,
   input  logic        req_zero_fill,
   output logic        item_push,
   input  logic        item_full,
   output item_type    item_word
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   logic     neg;

   assign req_full  = valid_ff && item_full;
   assign accept    = req_push && !req_full;
   assign item_push = valid_ff;
   assign item_word = item_ff;

   // Classify: sign, magnitude, saturated width and fill character.
   always_comb begin
      neg           = (req_mode == MODE_SDEC) && req_value[63];
      item_in.mag   = neg ? (64'd0 - req_value) : req_value;
      item_in.mode  = req_mode;
      item_in.neg   = neg;
      item_in.width = (req_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : req_width;
      item_in.left  = req_left_justify;
      item_in.fill  = req_zero_fill ? CHAR_ZERO : CHAR_SPACE;
   end

   // The stage holds its word until the queue takes it.
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (valid_ff && !item_full) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

### hw/rtl/itaf_back.sv
// Back end: converts the magnitude to digits and sends the characters one per cycle while the word queue has room.
`timescale 1ns / 1ps

module itaf_back
   import itaf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     item_empty,
   input  item_type item_word,
   output logic     item_pop,
   input  logic     rsp_full,
   output logic     rsp_push,
   output rsp_type  rsp_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_NORM,
      ST_SIGN,
      ST_PRE,
      ST_DIGITS,
      ST_POST
   } state_type;

   state_type             state_ff, state_in;
   item_type              cur_ff, cur_in;
   logic [DIGIT_BITS-1:0] dig_ff, dig_in;
   logic [63:0]           bin_ff, bin_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [4:0]            ndig_ff, ndig_in;
   logic [5:0]            pad_ff, pad_in;

   logic [DIGIT_BITS-1:0] adj;
   logic [DIGIT_BITS-1:0] oct;
   logic [65:0]           mag_ext;
   logic [3:0]            top_digit;
   logic [5:0]            pad_calc;
   logic                  is_dec;
   logic                  pre_needed;

   assign top_digit = dig_ff[DIGIT_BITS-1 -: 4];
   assign is_dec    = (cur_ff.mode == MODE_UDEC) || (cur_ff.mode == MODE_SDEC);
   assign pad_calc  = (cur_ff.width > {1'b0, ndig_ff}) ? cur_ff.width - {1'b0, ndig_ff} : '0;

   // Double dabble correction: add three to every digit of five or more.
   always_comb begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
         adj[4*k +: 4] = (dig_ff[4*k +: 4] >= 4'd5) ? dig_ff[4*k +: 4] + 4'd3
                                                     : dig_ff[4*k +: 4];
      end
   end

   // Octal digits are three-bit slices of the incoming magnitude.
   always_comb begin
      mag_ext = {2'b00, item_word.mag};
      for (int k = 0; k < NUM_DIGITS; k++) begin
         oct[4*k +: 4] = {1'b0, mag_ext[3*k +: 3]};
      end
   end

   // Sequencer: load, convert decimal numbers, strip leading zeros, then sign, leading fill, digits and trailing fill.
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      dig_in     = dig_ff;
      bin_in     = bin_ff;
      cnt_in     = cnt_ff;
      ndig_in    = ndig_ff;
      pad_in     = pad_ff;
      item_pop   = 1'b0;
      rsp_push   = 1'b0;
      rsp_word   = '0;
      pre_needed = !cur_ff.left && (pad_ff != '0);
      case (state_ff)
         ST_IDLE: begin
            if (!item_empty) begin
               item_pop = 1'b1;
               cur_in   = item_word;
               cnt_in   = 6'd63;
               ndig_in  = 5'(NUM_DIGITS);
               bin_in   = item_word.mag;
               if (item_word.mode == MODE_HEX) begin
                  dig_in   = {(DIGIT_BITS - 64)'(0), item_word.mag};
                  state_in = ST_NORM;
               end else if (item_word.mode == MODE_OCT) begin
                  dig_in   = oct;
                  state_in = ST_NORM;
               end else begin
                  dig_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            dig_in = {adj[DIGIT_BITS-2:0], bin_ff[63]};
            bin_in = {bin_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (top_digit == 4'd0 && ndig_ff != 5'd1) begin
               dig_in  = {dig_ff[DIGIT_BITS-5:0], 4'd0};
               ndig_in = ndig_ff - 1'b1;
            end else begin
               pad_in = pad_calc;
               if (cur_ff.neg) begin
                  state_in = ST_SIGN;
               end else if (!cur_ff.left && pad_calc != '0) begin
                  state_in = ST_PRE;
               end else begin
                  state_in = ST_DIGITS;
               end
            end
         end
         ST_SIGN: begin
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               rsp_word.ch   = CHAR_MINUS;
               rsp_word.last = 1'b0;
               state_in      = pre_needed ? ST_PRE : ST_DIGITS;
            end
         end
         ST_PRE: begin
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               rsp_word.ch   = cur_ff.fill;
               rsp_word.last = 1'b0;
               pad_in        = pad_ff - 1'b1;
               if (pad_ff == 6'd1) begin
                  state_in = ST_DIGITS;
               end
            end
         end
         ST_DIGITS: begin
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               rsp_word.ch   = digit_char(top_digit);
               rsp_word.last = (ndig_ff == 5'd1) && (pad_ff == '0);
               dig_in        = {dig_ff[DIGIT_BITS-5:0], 4'd0};
               ndig_in       = ndig_ff - 1'b1;
               if (ndig_ff == 5'd1) begin
                  state_in = (pad_ff != '0) ? ST_POST : ST_IDLE;
               end
            end
         end
         ST_POST: begin
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               rsp_word.ch   = cur_ff.fill;
               rsp_word.last = (pad_ff == 6'd1);
               pad_in        = pad_ff - 1'b1;
               if (pad_ff == 6'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cur_ff  <= cur_in;
      dig_ff  <= dig_in;
      bin_ff  <= bin_in;
      cnt_ff  <= cnt_in;
      ndig_ff <= ndig_in;
      pad_ff  <= pad_in;
   end

   // A decimal digit that reaches the output must be a valid BCD digit.
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS && is_dec) |-> (top_digit <= 4'd9))
      else $error("decimal digit out of range");

   // After the last shift the binary operand has been fully consumed.
   a_conv_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && cnt_ff == '0) |=> (bin_ff == '0))
      else $error("binary operand not consumed at end of conversion");

   // The word marked last ends the number and returns the sequencer to idle.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_word.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer still busy after the last word");

   // Digit output never runs past the digit count.
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS) |-> (ndig_ff != 5'd0))
      else $error("digit count exhausted while sending digits");

endmodule

### hw/rtl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: front end, item queue, back end, word queue.
//
//   channel   direction  handshake            payload
//   req       in         req_push / req_full   req_value, req_mode, req_width,
//                                              req_left_justify, req_zero_fill
//   rsp       out        rsp_pop / rsp_empty   rsp_ch, rsp_last
//
// Characters leave at one per cycle once the digits are ready, unless the word queue is full.
// After loading, a decimal number runs through the shift-and-correct steps of the double
// dabble converter; hex and octal skip that step. Leading zero digits are then stripped
// at one per cycle (up to 21 digits), and the fill count is set up once they are gone.
// Reset empties both queues and returns the sequencer to idle.
// A full word queue stalls the back end only; the front end keeps taking numbers
// until the item queue is full.
`timescale 1ns / 1ps

module integer_to_ascii_formatter
   import itaf_pkg::*;
#(
   parameter int ITEM_DEPTH = DEF_ITEM_DEPTH,
   parameter int RSP_DEPTH  = DEF_RSP_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_width,
   input  logic        req_left_justify,
   input  logic        req_zero_fill,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [7:0]  rsp_ch,
   output logic        rsp_last
);

   localparam int ITEM_BITS = $bits(item_type);
   localparam int RSP_BITS  = $bits(rsp_type);

   logic                 item_push, item_full, item_pop, item_empty;
   item_type             front_word, back_word;
   logic [ITEM_BITS-1:0] item_wdata, item_rdata;
   logic                 word_push, word_full;
   rsp_type              word_in, word_out;
   logic [RSP_BITS-1:0]  word_wdata, word_rdata;

   assign item_wdata = front_word;
   assign back_word  = item_type'(item_rdata);
   assign word_wdata = word_in;
   assign word_out   = rsp_type'(word_rdata);
   assign rsp_ch     = word_out.ch;
   assign rsp_last   = word_out.last;

   // Input side: classify each number.
   itaf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_value        (req_value),
      .req_mode         (req_mode),
      .req_width        (req_width),
      .req_left_justify (req_left_justify),
      .req_zero_fill    (req_zero_fill),
      .item_push        (item_push),
      .item_full        (item_full),
      .item_word        (front_word)
   );

   // Decouples the front end from the back end.
   itaf_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (ITEM_DEPTH)
   ) u_item_queue (
      .clock (clock),
      .reset (reset),
      .push  (item_push),
      .wdata (item_wdata),
      .full  (item_full),
      .pop   (item_pop),
      .rdata (item_rdata),
      .empty (item_empty)
   );

   // Digit conversion and character sequencing.
   itaf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (item_empty),
      .item_word  (back_word),
      .item_pop   (item_pop),
      .rsp_full   (word_full),
      .rsp_push   (word_push),
      .rsp_word   (word_in)
   );

   // Output words wait here until the consumer pops them.
   itaf_queue #(
      .WIDTH (RSP_BITS),
      .DEPTH (RSP_DEPTH)
   ) u_word_queue (
      .clock (clock),
      .reset (reset),
      .push  (word_push),
      .wdata (word_wdata),
      .full  (word_full),
      .pop   (rsp_pop),
      .rdata (word_rdata),
      .empty (rsp_empty)
   );

endmodule

### test/testbench.sv
// Self-checking testbench for the integer to ASCII formatter.
`timescale 1ns / 1ps

module testbench;
   import itaf_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 600;

   // One number to format, as offered on the request ports.
   typedef struct {
      logic [63:0] value;
      logic [1:0]  mode;
      logic [5:0]  width;
      logic        left;
      logic        zero;
   } number_type;

   // Keeps the characters still owed by the block and checks each one that leaves it.
   class ascii_scoreboard;
      rsp_type expected_chars[$];
      int      mismatches;

      // Formats one accepted number and queues its characters.
      function void note_number(number_type num);
         string       digit_text = "0123456789ABCDEF";
         logic [63:0] mag;
         logic [63:0] base;
         logic [7:0]  digits[$];
         logic [7:0]  text[$];
         logic [7:0]  pad;
         int          field;
         rsp_type     word;
         mag = num.value;
         if (num.mode == MODE_HEX) begin
            base = 64'd16;
         end else if (num.mode == MODE_OCT) begin
            base = 64'd8;
         end else begin
            base = 64'd10;
         end
         // A negative signed number gets its sign ahead of any fill.
         if (num.mode == MODE_SDEC && num.value[63]) begin
            text.push_back(CHAR_MINUS);
            mag = -num.value;
         end
         do begin
            digits.push_front(digit_text[int'(mag % base)]);
            mag = mag / base;
         end while (mag != 64'd0);
         field = (num.width > MAX_WIDTH) ? MAX_WIDTH : int'(num.width);
         pad = num.zero ? CHAR_ZERO : CHAR_SPACE;
         if (!num.left) begin
            for (int i = digits.size(); i < field; i++) text.push_back(pad);
         end
         foreach (digits[i]) text.push_back(digits[i]);
         if (num.left) begin
            for (int i = digits.size(); i < field; i++) text.push_back(pad);
         end
         foreach (text[i]) begin
            word.ch   = text[i];
            word.last = (i == text.size() - 1);
            expected_chars.push_back(word);
         end
      endfunction

      // Compares one accepted character word with the oldest one owed.
      function void check_char(logic [7:0] ch, logic last);
         rsp_type want;
         if (expected_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected word: ch %h last %b", ch, last);
            end
            return;
         end
         want = expected_chars.pop_front();
         if (want.ch !== ch || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected ch %h last %b, got ch %h last %b",
                        want.ch, want.last, ch, last);
            end
         end
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] req_value = '0;
   logic [1:0]  req_mode = MODE_UDEC;
   logic [5:0]  req_width = '0;
   logic        req_left_justify = 1'b0;
   logic        req_zero_fill = 1'b0;
   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic [7:0]  rsp_ch;
   logic        rsp_last;

   ascii_scoreboard board;
   bit              calm = 1'b0;
   bit              hold_request = 1'b0;
   int unsigned     cycles = 0;

   integer_to_ascii_formatter dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_value        (req_value),
      .req_mode         (req_mode),
      .req_width        (req_width),
      .req_left_justify (req_left_justify),
      .req_zero_fill    (req_zero_fill),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_ch           (rsp_ch),
      .rsp_last         (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic number_type make_number(logic [63:0] value, logic [1:0] mode,
                                              int width, int left, int zero);
      number_type num;
      num.value = value;
      num.mode  = mode;
      num.width = 6'(width);
      num.left  = 1'(left);
      num.zero  = 1'(zero);
      return num;
   endfunction

   // Values lean toward small numbers, negatives and powers of two.
   function automatic logic [63:0] random_value();
      logic [63:0] full;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return full;
         1: return 64'($urandom_range(0, 999));
         2: return -64'($urandom_range(1, 999));
         3: return (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
         4: return full >> $urandom_range(0, 63);
         default: return full | 64'h8000_0000_0000_0000;
      endcase
   endfunction

   // Most numbers use narrow fields so the run stays short.
   function automatic number_type random_number();
      int width;
      width = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
      return make_number(random_value(), 2'($urandom_range(0, 3)), width,
                         int'($urandom_range(0, 1)), int'($urandom_range(0, 1)));
   endfunction

   // Offers one number and returns at the edge that accepts it.
   task automatic offer_number(number_type num);
      req_value        <= num.value;
      req_mode         <= num.mode;
      req_width        <= num.width;
      req_left_justify <= num.left;
      req_zero_fill    <= num.zero;
      req_push         <= 1'b1;
      do @(posedge clock); while (req_full);
      board.note_number(num);
   endtask

   // Sometimes the sender goes quiet for a few cycles.
   task automatic sender_gap();
      if (!calm && $urandom_range(0, 99) < 12) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Receiver: check every accepted word, then choose whether to pop next cycle.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) board.check_char(rsp_ch, rsp_last);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 12) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Sender: directed numbers, then random ones in several phases.
   initial begin
      number_type directed[$];
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(make_number(64'd0, MODE_UDEC, 0, 0, 0));
      directed.push_back(make_number(64'd0, MODE_HEX, 5, 0, 1));
      directed.push_back(make_number(64'd0, MODE_OCT, 4, 1, 1));
      directed.push_back(make_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_UDEC, 0, 0, 0));
      directed.push_back(make_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_OCT, 0, 0, 0));
      directed.push_back(make_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_HEX, 0, 0, 0));
      directed.push_back(make_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_SDEC, 0, 0, 0));
      directed.push_back(make_number(64'h8000_0000_0000_0000, MODE_SDEC, 0, 0, 0));
      directed.push_back(make_number(64'h8000_0000_0000_0000, MODE_SDEC, 63, 0, 1));
      directed.push_back(make_number(64'h7FFF_FFFF_FFFF_FFFF, MODE_SDEC, 0, 0, 0));
      directed.push_back(make_number(64'hFFFF_FFFF_FFFF_FFFB, MODE_SDEC, 5, 0, 1));
      directed.push_back(make_number(64'hFFFF_FFFF_FFFF_FFFB, MODE_SDEC, 5, 1, 0));
      directed.push_back(make_number(64'hFFFF_FFFF_FFFF_FFFB, MODE_SDEC, 5, 1, 1));
      directed.push_back(make_number(64'd12345, MODE_UDEC, 10, 1, 0));
      directed.push_back(make_number(64'hDEAD_BEEF, MODE_HEX, 63, 1, 1));
      directed.push_back(make_number(64'd8, MODE_OCT, 63, 0, 0));
      directed.push_back(make_number(64'd42, MODE_UDEC, 1, 0, 1));
      directed.push_back(make_number(64'd1, MODE_UDEC, 63, 0, 1));
      directed.push_back(make_number(64'd7, MODE_SDEC, 3, 0, 0));
      directed.push_back(make_number(64'hFEDC_BA98_7654_3210, MODE_HEX, 0, 0, 0));
      directed.push_back(make_number(64'hFFFF_FFFF_FFFF_FFFF, MODE_SDEC, 63, 1, 1));
      directed.push_back(make_number(64'd10000000000000000000, MODE_UDEC, 20, 0, 1));
      foreach (directed[i]) begin
         offer_number(directed[i]);
         sender_gap();
      end
      drain_results();

      // Back to back on both sides.
      calm = 1'b1;
      repeat (60) offer_number(random_number());
      calm = 1'b0;

      // The receiver stops for a long while; the sender keeps offering until stalled.
      hold_request = 1'b1;
      repeat (40) begin
         offer_number(random_number());
         sender_gap();
      end
      drain_results();

      repeat (130) begin
         offer_number(random_number());
         sender_gap();
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
